[src/kth_match_segment_tree_unit_defines.svh]
// Assertion macros for the k-th match segment tree unit.
// Sampled on i_clk, disabled while i_rst_n is low; no other dependencies.
`ifndef KTH_MATCH_SEGMENT_TREE_UNIT_DEFINES_SVH
`define KTH_MATCH_SEGMENT_TREE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KMST_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kmst_pkg.sv]
// Shared types and constants for the k-th match segment tree unit.
// No dependencies; imported by every module of the block but kmst_ram.
package kmst_pkg;

    localparam int POS_W = 11;
    localparam int VAL_W = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] new_value;
        logic [POS_W-1:0]        range_start;
        logic [POS_W-1:0]        range_end;
        logic [POS_W-1:0]        rank;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_UP,
        ST_Q_TOTAL,
        ST_Q_PREFIX,
        ST_Q_SELECT,
        ST_Q_DONE
    } t_state;

endpackage

[src/kmst_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kmst_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/kmst_engine.sv]
// Command sequencer and count-tree datapath: leaf writes with path update,
// prefix count, k-th select. Depends on kmst_pkg and kmst_ram.
module kmst_engine #(
    parameter int NUM_LEAVES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [kmst_pkg::VAL_W-1:0]   i_cfg_data,
    input  logic                         i_item_valid,
    output logic                         o_item_ready,
    input  kmst_pkg::t_in_item           i_item,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output kmst_pkg::t_out_item          o_res
);
    import kmst_pkg::*;

    localparam int LOG   = (NUM_LEAVES > 1) ? $clog2(NUM_LEAVES) : 1;
    localparam int AW    = LOG + 1;
    localparam int DEPTH = 2 << LOG;
    localparam int CW    = $clog2(NUM_LEAVES + 1);
    localparam int KW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int PW    = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int JW    = (LOG > 1) ? $clog2(LOG) : 1;

    t_state                  r_state, n_state;
    logic signed [VAL_W-1:0] r_target, n_target;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [AW-1:0]           r_node, n_node;
    logic [AW-1:0]           r_path, n_path;
    logic [CW-1:0]           r_acc, n_acc;
    logic [CW-1:0]           r_total, n_total;
    logic [JW-1:0]           r_j, n_j;
    logic                    r_take, n_take;
    logic [KW-1:0]           r_k, n_k;
    logic [POS_W-1:0]        r_rank, n_rank;
    logic [PW-1:0]           r_rend, n_rend;
    t_out_item               r_res, n_res;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [CW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [CW-1:0]           ram_rdata;

    logic                    accept;
    logic [PW-1:0]           wr_idx;
    logic                    wr_ok;
    logic [AW-1:0]           wr_leaf;
    logic                    wr_match;
    logic [POS_W-1:0]        q_lo;
    logic [PW-1:0]           q_hi;
    logic                    q_ok;
    logic [PW-1:0]           q_lim;
    logic [CW-1:0]           up_sum;
    logic [AW-1:0]           up_parent;
    logic                    up_last;
    logic [CW-1:0]           pf_sum;
    logic [KW-1:0]           want;
    logic                    want_ok;
    logic [JW-1:0]           sh_amt;
    logic [AW-1:0]           pf_sh;
    logic [AW-1:0]           pf_addr;
    logic                    sel_left;
    logic [AW-1:0]           sel_child;
    logic                    sel_leaf;
    logic [PW-1:0]           sel_pos;
    logic                    sel_found;

    kmst_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_item_ready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign accept       = i_item_valid && o_item_ready;
    assign o_res_valid  = (r_state == ST_Q_DONE);
    assign o_res        = r_res;

    assign wr_idx   = PW'(i_item.position) - PW'(1);
    assign wr_ok    = (i_item.position != '0) && (PW'(i_item.position) <= PW'(NUM_LEAVES));
    assign wr_leaf  = {1'b1, wr_idx[LOG-1:0]};
    assign wr_match = (i_item.new_value == r_target);

    assign q_lo  = (i_item.range_start == '0) ? POS_W'(1) : i_item.range_start;
    assign q_hi  = (PW'(i_item.range_end) > PW'(NUM_LEAVES)) ? PW'(NUM_LEAVES)
                                                            : PW'(i_item.range_end);
    assign q_ok  = (i_item.rank != '0) && (PW'(q_lo) <= q_hi);
    assign q_lim = PW'(q_lo) - PW'(1);

    assign up_sum    = r_acc + ram_rdata;
    assign up_parent = r_node >> 1;
    assign up_last   = (up_parent == AW'(1));

    assign pf_sum  = r_take ? (r_acc + ram_rdata) : r_acc;
    assign want    = KW'(pf_sum) + KW'(r_rank);
    assign want_ok = (want <= KW'(r_total));
    assign sh_amt  = (r_state == ST_Q_TOTAL) ? JW'(LOG - 1) : (r_j - JW'(1));
    assign pf_sh   = r_path >> sh_amt;
    assign pf_addr = {pf_sh[AW-1:1], 1'b0};

    assign sel_left  = (KW'(ram_rdata) >= r_k);
    assign sel_child = {r_node[AW-2:0], ~sel_left};
    assign sel_leaf  = sel_child[AW-1];
    assign sel_pos   = PW'(sel_child[LOG-1:0]) + PW'(1);
    assign sel_found = (sel_pos <= r_rend);

    always_comb begin
        n_state = r_state;
        if (i_cfg_valid) begin
            n_state = ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == '1) n_state = ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        if (i_item.cmd == CMD_QUERY) begin
                            n_state = q_ok ? ST_Q_TOTAL : ST_Q_DONE;
                        end else if (wr_ok) begin
                            n_state = ST_WR_UP;
                        end
                    end
                end
                ST_WR_UP: begin
                    if (up_last) n_state = ST_IDLE;
                end
                ST_Q_TOTAL: begin
                    n_state = ST_Q_PREFIX;
                end
                ST_Q_PREFIX: begin
                    if (r_j == '0) n_state = want_ok ? ST_Q_SELECT : ST_Q_DONE;
                end
                ST_Q_SELECT: begin
                    if (sel_leaf) n_state = ST_Q_DONE;
                end
                ST_Q_DONE: begin
                    if (i_res_ready) n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_target   = r_target;
        n_clr_addr = r_clr_addr;
        n_node     = r_node;
        n_path     = r_path;
        n_acc      = r_acc;
        n_total    = r_total;
        n_j        = r_j;
        n_take     = r_take;
        n_k        = r_k;
        n_rank     = r_rank;
        n_rend     = r_rend;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = r_clr_addr;
        ram_wdata  = '0;
        ram_raddr  = AW'(1);

        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.cmd == CMD_WRITE) begin
                        if (wr_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = wr_leaf;
                            ram_wdata = CW'(wr_match);
                            ram_raddr = wr_leaf ^ AW'(1);
                            n_node    = wr_leaf;
                            n_acc     = CW'(wr_match);
                        end
                    end else begin
                        ram_raddr = AW'(1);
                        n_path    = {1'b1, q_lim[LOG-1:0]};
                        n_rank    = i_item.rank;
                        n_rend    = q_hi;
                        n_acc     = '0;
                        n_res     = '0;
                    end
                end
            end
            ST_WR_UP: begin
                ram_we    = 1'b1;
                ram_waddr = up_parent;
                ram_wdata = up_sum;
                ram_raddr = up_parent ^ AW'(1);
                n_node    = up_parent;
                n_acc     = up_sum;
            end
            ST_Q_TOTAL: begin
                n_total   = ram_rdata;
                ram_raddr = pf_addr;
                n_take    = pf_sh[0];
                n_j       = sh_amt;
            end
            ST_Q_PREFIX: begin
                n_acc = pf_sum;
                if (r_j != '0) begin
                    ram_raddr = pf_addr;
                    n_take    = pf_sh[0];
                    n_j       = sh_amt;
                end else begin
                    ram_raddr = AW'(2);
                    n_node    = AW'(1);
                    n_k       = want;
                end
            end
            ST_Q_SELECT: begin
                n_k       = sel_left ? r_k : (r_k - KW'(ram_rdata));
                n_node    = sel_child;
                ram_raddr = {sel_child[AW-2:0], 1'b0};
                if (sel_leaf) begin
                    n_res.found          = sel_found;
                    n_res.match_position = sel_found ? sel_pos[POS_W-1:0] : '0;
                end
            end
            ST_Q_DONE: begin
            end
        endcase

        if (i_cfg_valid) begin
            n_target   = i_cfg_data;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_target   <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_target   <= n_target;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_path  <= n_path;
        r_acc   <= n_acc;
        r_total <= n_total;
        r_j     <= n_j;
        r_take  <= n_take;
        r_k     <= n_k;
        r_rank  <= n_rank;
        r_rend  <= n_rend;
        r_res   <= n_res;
    end

endmodule

[src/kth_match_segment_tree_unit.sv]
// Top level of the k-th match segment tree unit: config port, output register.
// Depends on kmst_pkg and kmst_engine.
//
// Usage:
//   Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) sets the target value and
//   starts a clearing pass over all 2*2^ceil(log2(NUM_LEAVES)) words of the count
//   tree memory (2048 at the default), during which o_in_ready is low. Reset starts
//   the same pass with a target of zero.
//   Input channel (i_in_valid/o_in_ready/i_in_data) takes one command at a time.
//   A write walks its leaf-to-root path, one tree level a cycle, and gives no
//   result. A write outside 1..NUM_LEAVES is dropped in its accept cycle.
//   A query reads the root count, descends the prefix path and then the select
//   path, one level a cycle each through the one read port of the tree memory;
//   an empty range or a rank of zero goes straight to a not-found result. The next
//   command is taken once the result has passed to the output register.
//   Output channel (o_out_valid/i_out_ready/o_out_data) is a register; the next
//   command is taken while a result waits. A stalled receiver holds a finished
//   query in its last step until the register frees up.
module kth_match_segment_tree_unit #(
    parameter int NUM_LEAVES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [kmst_pkg::VAL_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  kmst_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output kmst_pkg::t_out_item        o_out_data
);
    import kmst_pkg::*;

    logic      res_valid;
    logic      res_ready;
    t_out_item res;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data;

    kmst_engine #(
        .NUM_LEAVES (NUM_LEAVES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (i_in_valid),
        .o_item_ready (o_in_ready),
        .i_item       (i_in_data),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign o_cfg_ready = 1'b1;
    assign res_ready   = !r_out_valid || i_out_ready;
    assign n_out_valid = res_valid || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[src/kmst_checker.sv]
// Port-level assertions for the k-th match segment tree unit, bound to the top.
// Depends on kmst_pkg and kth_match_segment_tree_unit_defines.svh.
`include "kth_match_segment_tree_unit_defines.svh"

module kmst_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input kmst_pkg::t_out_item        o_out_data
);
    import kmst_pkg::*;

    logic out_stall;
    logic out_miss;
    logic out_hit;
    logic cfg_xfer;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_miss  = o_out_valid && !o_out_data.found;
    assign out_hit   = o_out_valid && o_out_data.found;
    assign cfg_xfer  = i_cfg_valid && o_cfg_ready;

    `KMST_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data), "result moved")

    `KMST_ASSERT_IMPLIES(a_miss_zero, out_miss, o_out_data.match_position == '0, "stray position")

    `KMST_ASSERT_IMPLIES(a_hit_nonzero, out_hit, o_out_data.match_position != '0, "hit at zero")

    `KMST_ASSERT_NEXT(a_cfg_clears, cfg_xfer, !o_in_ready, "command taken while clearing")

endmodule

bind kth_match_segment_tree_unit kmst_checker u_kmst_checker (.*);
